// ===== rtl/mexp_pkg.sv =====
// shared types and constants for the modular exponentiation block
// no dependencies
package mexp_pkg;

	// width of the payload ports
	localparam int FIELD_W = 64;
	// default arithmetic width
	localparam int WIDTH_DEF = 64;

	// control of the bit cell chain
	typedef struct packed {
		logic ld_e;
		logic ld_b;
		logic sh_e;
		logic sh_b;
	} chain_ctl_t;

endpackage

// ===== rtl/modular_exponentiation.sv =====
// modular exponentiation, right-to-left binary method with shift-add modular multiply
// depends on mexp_pkg and mexp_chain
//
// channel   signals                                 handshake
// command   start, base, exponent, modulus          accepted when start and not busy
// result    done, power_mod, zero_modulus           done high for one cycle, no stall
//
// the base is reduced first; then per exponent bit, a multiply into the accumulator when
// the bit is set and a squaring of the base while higher exponent bits remain.
// the single add-compare-subtract unit does one doubling or add per cycle.
// a zero modulus answers in the cycle after the command and leaves busy low.
// reset clears the control state; operand registers are not reset.
// busy is high from the cycle after the accepted beat until the result beat.
module modular_exponentiation
	import mexp_pkg::*;
#(
	parameter int WIDTH = WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [FIELD_W-1:0] base,
	input  logic [FIELD_W-1:0] exponent,
	input  logic [FIELD_W-1:0] modulus,
	output logic               done,
	output logic [FIELD_W-1:0] power_mod,
	output logic               zero_modulus
);

	localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RED  = 3'd1;
	localparam logic [2:0] S_CHK  = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_SQ   = 3'd4;

	logic [2:0]       state_q;
	logic [CW-1:0]    cnt_q;
	logic             ph_q;
	logic             tgt_q;
	logic             mdone_q;
	logic             done_q;
	logic             err_q;
	logic [WIDTH-1:0] m_q;
	logic [WIDTH-1:0] sq_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] p_q;
	logic [WIDTH-1:0] res_q;

	chain_ctl_t       ctl;
	logic [WIDTH-1:0] b_ld;
	logic [WIDTH-1:0] e_vec;
	logic             b_msb;
	logic             accept;

	logic [WIDTH-1:0] mul_a;
	logic [WIDTH-1:0] addend;
	logic             cin;
	logic [WIDTH:0]   sum;
	logic [WIDTH-1:0] red;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	mexp_chain #(.WIDTH(WIDTH)) u_chain (
		.clk  (clk),
		.ctl  (ctl),
		.e_ld (exponent[WIDTH-1:0]),
		.b_ld (b_ld),
		.e_vec(e_vec),
		.b_msb(b_msb)
	);

	// shared add, compare and subtract: p plus addend plus carry in, reduced once
	assign mul_a  = tgt_q ? sq_q : acc_q;
	assign addend = (state_q == S_MUL && ph_q) ? mul_a : p_q;
	assign cin    = (state_q == S_RED) ? b_msb : 1'b0;
	assign sum    = {1'b0, p_q} + {1'b0, addend} + {{WIDTH{1'b0}}, cin};
	assign red    = (sum >= {1'b0, m_q}) ? WIDTH'(sum - {1'b0, m_q}) : sum[WIDTH-1:0];

	// chain control
	always_comb begin
		ctl  = '0;
		b_ld = base[WIDTH-1:0];
		case (state_q)
			S_IDLE: begin
				ctl.ld_e = accept;
				ctl.ld_b = accept;
			end
			S_RED: begin
				ctl.sh_b = 1'b1;
			end
			S_CHK: begin
				b_ld = sq_q;
				if (e_vec != '0) begin
					if (e_vec[0] && !mdone_q) begin
						ctl.ld_b = 1'b1;
					end else begin
						ctl.sh_e = 1'b1;
					end
				end
			end
			S_SQ: begin
				b_ld     = sq_q;
				ctl.ld_b = (e_vec != '0);
			end
			S_MUL: begin
				ctl.sh_b = ph_q;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			ph_q    <= 1'b0;
			tgt_q   <= 1'b0;
			mdone_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (modulus[WIDTH-1:0] == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_RED;
							cnt_q   <= CW'(WIDTH - 1);
						end
					end
				end
				S_RED: begin
					if (cnt_q == '0) begin
						state_q <= S_CHK;
						mdone_q <= 1'b0;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_CHK: begin
					if (e_vec == '0) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else if (e_vec[0] && !mdone_q) begin
						state_q <= S_MUL;
						tgt_q   <= 1'b0;
						ph_q    <= 1'b0;
						cnt_q   <= CW'(WIDTH - 1);
					end else begin
						state_q <= S_SQ;
						mdone_q <= 1'b0;
					end
				end
				S_SQ: begin
					if (e_vec == '0) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_MUL;
						tgt_q   <= 1'b1;
						ph_q    <= 1'b0;
						cnt_q   <= CW'(WIDTH - 1);
					end
				end
				S_MUL: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (cnt_q == '0) begin
							state_q <= S_CHK;
							mdone_q <= !tgt_q;
						end else begin
							cnt_q <= cnt_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					m_q   <= modulus[WIDTH-1:0];
					p_q   <= '0;
					err_q <= (modulus[WIDTH-1:0] == '0);
					res_q <= '0;
				end
			end
			S_RED: begin
				p_q <= red;
				if (cnt_q == '0) begin
					sq_q  <= red;
					acc_q <= (m_q == WIDTH'(1)) ? '0 : WIDTH'(1);
				end
			end
			S_CHK: begin
				p_q <= '0;
				if (e_vec == '0) begin
					res_q <= acc_q;
				end
			end
			S_SQ: begin
				p_q <= '0;
				if (e_vec == '0) begin
					res_q <= acc_q;
				end
			end
			S_MUL: begin
				if (!ph_q || b_msb) begin
					p_q <= red;
				end
				if (ph_q && cnt_q == '0) begin
					if (tgt_q) begin
						sq_q <= b_msb ? red : p_q;
					end else begin
						acc_q <= b_msb ? red : p_q;
					end
				end
			end
			default: begin
				p_q <= p_q;
			end
		endcase
	end

	assign done         = done_q;
	assign power_mod    = FIELD_W'(res_q);
	assign zero_modulus = err_q;

`ifndef SYNTHESIS
	// a result beat only comes once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result beat while busy");

	// an error beat carries a zero result
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_modulus) |-> (power_mod == '0)) else $error("error result not zero");

	// partial product stays reduced during a multiply
	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> (p_q < m_q)) else $error("partial product not reduced");

	// a nonzero modulus command makes the block busy
	a_go_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && modulus[WIDTH-1:0] != '0) |=> busy) else $error("command not taken");
`endif

endmodule

// ===== rtl/mexp_cell.sv =====
// one bit cell: an exponent bit that moves right and an operand bit that moves left
// depends on mexp_pkg
module mexp_cell
	import mexp_pkg::*;
(
	input  logic       clk,
	input  chain_ctl_t ctl,
	input  logic       e_ld,
	input  logic       b_ld,
	input  logic       e_nb,
	input  logic       b_nb,
	output logic       e_bit,
	output logic       b_bit
);

	logic e_q;
	logic b_q;

	// exponent bit
	always_ff @(posedge clk) begin
		if (ctl.ld_e) begin
			e_q <= e_ld;
		end else if (ctl.sh_e) begin
			e_q <= e_nb;
		end
	end

	// multiplier operand bit
	always_ff @(posedge clk) begin
		if (ctl.ld_b) begin
			b_q <= b_ld;
		end else if (ctl.sh_b) begin
			b_q <= b_nb;
		end
	end

	assign e_bit = e_q;
	assign b_bit = b_q;

endmodule

// ===== rtl/mexp_chain.sv =====
// row of bit cells holding the exponent and the multiplier operand
// depends on mexp_pkg and mexp_cell
module mexp_chain
	import mexp_pkg::*;
#(
	parameter int WIDTH = WIDTH_DEF
) (
	input  logic             clk,
	input  chain_ctl_t       ctl,
	input  logic [WIDTH-1:0] e_ld,
	input  logic [WIDTH-1:0] b_ld,
	output logic [WIDTH-1:0] e_vec,
	output logic             b_msb
);

	logic [WIDTH-1:0] b_vec;

	// each cell takes the exponent from its upper neighbor and the operand from its lower one
	for (genvar i = 0; i < WIDTH; i++) begin : g_cell
		logic e_nb;
		logic b_nb;
		if (i == WIDTH - 1) begin : g_top
			assign e_nb = 1'b0;
		end else begin : g_mid
			assign e_nb = e_vec[i+1];
		end
		if (i == 0) begin : g_bot
			assign b_nb = 1'b0;
		end else begin : g_up
			assign b_nb = b_vec[i-1];
		end
		mexp_cell u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.e_ld (e_ld[i]),
			.b_ld (b_ld[i]),
			.e_nb (e_nb),
			.b_nb (b_nb),
			.e_bit(e_vec[i]),
			.b_bit(b_vec[i])
		);
	end

	assign b_msb = b_vec[WIDTH-1];

endmodule
